// ----- sv/rsse_pkg.sv -----
// Shared types and constants for the rectangle shadow silhouette extruder.
// No dependencies; imported by rsse_extrude and the top level.
package rsse_pkg;

    localparam int CW = 24;   // input coordinate width
    localparam int VW = 27;   // output vertex width
    localparam int LW = 17;   // extrusion length width

    localparam logic [1:0] OC_VERTEX = 2'd0;
    localparam logic [1:0] OC_INSIDE = 2'd1;
    localparam logic [1:0] OC_EMPTY  = 2'd2;

    // rectangle corners
    localparam logic [1:0] CRN_LT = 2'd0;
    localparam logic [1:0] CRN_RT = 2'd1;
    localparam logic [1:0] CRN_RB = 2'd2;
    localparam logic [1:0] CRN_LB = 2'd3;

    localparam logic [LW-1:0] LEN_RESET = 17'd100000;

    localparam logic signed [VW-1:0] VMAX = 27'sh3FFFFFF;
    localparam logic signed [VW-1:0] VMIN = 27'sh4000000;

    typedef enum logic [2:0] {
        T_IDLE,
        T_STATUS,
        T_CORNER,
        T_EXT,
        T_WAIT,
        T_PUT
    } top_state_t;

    typedef enum logic [3:0] {
        X_IDLE,
        X_SQA,
        X_SQB,
        X_SUM,
        X_NORM,
        X_SQRT,
        X_MUL,
        X_NUM,
        X_DIV,
        X_DONE
    } ext_state_t;

    typedef struct packed {
        logic                 start;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
    } ext_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [VW-1:0] ex;
        logic signed [VW-1:0] ey;
    } ext_rsp_t;

endpackage

// ----- sv/rsse_extrude.sv -----
// Corner extrusion unit: one shared multiplier, square root and divider steps.
// Depends on rsse_pkg.
module rsse_extrude #(
    parameter int FRAC_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rsse_pkg::ext_req_t           req,
    input  logic signed [rsse_pkg::CW-1:0] lx,
    input  logic signed [rsse_pkg::CW-1:0] ly,
    input  logic [rsse_pkg::LW-1:0]      len,
    output rsse_pkg::ext_rsp_t           rsp
);
    import rsse_pkg::*;

    localparam int AW  = CW;                  // |d| width
    localparam int DW  = 58;                  // normalized distance squared
    localparam int RW  = 29;                  // root width
    localparam int PW  = RW + AW;             // multiplier product
    localparam int SHW = AW + 32;             // |d| << s before truncation
    localparam int QW  = LW + FRAC_BITS;      // quotient width
    localparam int NW  = RW + LW + FRAC_BITS + 1;
    localparam int SW  = (QW + 2 > VW) ? QW + 2 : VW;
    localparam int CNW = $clog2(QW + 1);
    localparam logic [DW-1:0] NORM_MIN = DW'(1) << 56;

    ext_state_t           state_reg, state_next;
    logic signed [CW-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic [AW-1:0]        ax_reg, ay_reg, ax_next, ay_next;
    logic                 sx_reg, sy_reg, sx_next, sy_next;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [DW-1:0]        d_reg, d_next, res_reg, res_next, bit_reg, bit_next;
    logic [4:0]           s_reg, s_next;
    logic                 axis_reg, axis_next;
    logic [RW-1:0]        rem_reg, rem_next;
    logic [QW-1:0]        quo_reg, quo_next, ox_reg, ox_next, oy_reg, oy_next;
    logic [CNW-1:0]       cnt_reg, cnt_next;

    logic signed [AW:0]   dx, dy;
    logic [RW-1:0]        mul_a;
    logic [AW-1:0]        mul_b;
    logic [SHW-1:0]       ash_full;
    logic [DW-1:0]        dsum, rb;
    logic [NW-1:0]        num;
    logic [RW:0]          t, diff;
    logic                 ge;
    logic signed [SW-1:0] sumx, sumy;

    function automatic logic signed [VW-1:0] sat_v(input logic signed [SW-1:0] v);
        if (v > SW'(VMAX))
            return VMAX;
        else if (v < SW'(VMIN))
            return VMIN;
        else
            return v[VW-1:0];
    endfunction

    assign dx = {req.cx[CW-1], req.cx} - {lx[CW-1], lx};
    assign dy = {req.cy[CW-1], req.cy} - {ly[CW-1], ly};

    assign ash_full = SHW'(axis_reg ? ay_reg : ax_reg) << s_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = RW'(ax_reg);
        mul_b = ax_reg;
        case (state_reg)
            X_SQB:
            begin
                mul_a = RW'(ay_reg);
                mul_b = ay_reg;
            end
            X_MUL:
            begin
                mul_a = ash_full[RW-1:0];
                mul_b = AW'(len);
            end
            default:
            begin
                mul_a = RW'(ax_reg);
                mul_b = ax_reg;
            end
        endcase
    end

    assign dsum = d_reg + DW'(prod_reg);
    assign rb   = res_reg + bit_reg;
    assign num  = (NW'(prod_reg) << FRAC_BITS) + NW'(res_reg[RW-1:1]);
    assign t    = {rem_reg, quo_reg[QW-1]};
    assign diff = t - {1'b0, res_reg[RW-1:0]};
    assign ge   = t >= {1'b0, res_reg[RW-1:0]};

    assign sumx = sx_reg ? SW'(cx_reg) - SW'($signed({1'b0, ox_reg}))
                         : SW'(cx_reg) + SW'($signed({1'b0, ox_reg}));
    assign sumy = sy_reg ? SW'(cy_reg) - SW'($signed({1'b0, oy_reg}))
                         : SW'(cy_reg) + SW'($signed({1'b0, oy_reg}));

    always_comb
    begin
        state_next = state_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        prod_next  = prod_reg;
        d_next     = d_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        s_next     = s_reg;
        axis_next  = axis_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        cnt_next   = cnt_reg;
        rsp.done   = 1'b0;
        rsp.ex     = sat_v(sumx);
        rsp.ey     = sat_v(sumy);
        case (state_reg)
            X_IDLE:
            begin
                if (req.start)
                begin
                    cx_next    = req.cx;
                    cy_next    = req.cy;
                    sx_next    = dx[AW];
                    sy_next    = dy[AW];
                    ax_next    = dx[AW] ? AW'(-dx) : dx[AW-1:0];
                    ay_next    = dy[AW] ? AW'(-dy) : dy[AW-1:0];
                    state_next = X_SQA;
                end
            end
            X_SQA:
            begin
                prod_next  = PW'(mul_a) * PW'(mul_b);
                state_next = X_SQB;
            end
            X_SQB:
            begin
                d_next     = DW'(prod_reg);
                prod_next  = PW'(mul_a) * PW'(mul_b);
                state_next = X_SUM;
            end
            X_SUM:
            begin
                d_next = dsum;
                s_next = '0;
                if (dsum == '0)
                begin
                    // light on the corner: no push
                    ox_next    = '0;
                    oy_next    = '0;
                    state_next = X_DONE;
                end
                else
                    state_next = X_NORM;
            end
            X_NORM:
            begin
                if (d_reg < NORM_MIN)
                begin
                    d_next = d_reg << 2;
                    s_next = s_reg + 5'd1;
                end
                else
                begin
                    res_next   = '0;
                    bit_next   = NORM_MIN;
                    state_next = X_SQRT;
                end
            end
            X_SQRT:
            begin
                if (d_reg >= rb)
                begin
                    d_next   = d_reg - rb;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                    res_next = res_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    axis_next  = 1'b0;
                    state_next = X_MUL;
                end
            end
            X_MUL:
            begin
                prod_next  = PW'(mul_a) * PW'(mul_b);
                state_next = X_NUM;
            end
            X_NUM:
            begin
                rem_next   = num[QW+RW-1:QW];
                quo_next   = num[QW-1:0];
                cnt_next   = '0;
                state_next = X_DIV;
            end
            X_DIV:
            begin
                rem_next = ge ? diff[RW-1:0] : t[RW-1:0];
                quo_next = {quo_reg[QW-2:0], ge};
                cnt_next = cnt_reg + CNW'(1);
                if (cnt_reg == CNW'(QW - 1))
                begin
                    if (axis_reg)
                    begin
                        oy_next    = {quo_reg[QW-2:0], ge};
                        state_next = X_DONE;
                    end
                    else
                    begin
                        ox_next    = {quo_reg[QW-2:0], ge};
                        axis_next  = 1'b1;
                        state_next = X_MUL;
                    end
                end
            end
            X_DONE:
            begin
                rsp.done   = 1'b1;
                state_next = X_IDLE;
            end
            default:
                state_next = X_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= X_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        prod_reg <= prod_next;
        d_reg    <= d_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        s_reg    <= s_next;
        axis_reg <= axis_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        cnt_reg  <= cnt_next;
    end

`ifndef ASSERT_OFF
    a_rem_below_root: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == X_DIV |-> rem_reg < res_reg[RW-1:0])
        else $error("divider remainder not below root");
    a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == X_SQRT |-> $onehot(bit_reg))
        else $error("square root bit lost");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == X_DONE |=> state_reg == X_IDLE)
        else $error("done held more than one cycle");
`endif

endmodule

// ----- sv/rect_shadow_silhouette_extruder.sv -----
// Top level: region classification, vertex sequencing and output register.
// Depends on rsse_pkg and rsse_extrude.
// Status results are registered from the T_STATUS state once the output is free; silhouette corners
// follow at one per cycle while out_ready does not stall them. Each extruded vertex runs the extrusion
// steps (s up to 28 normalize steps; 29 root steps; one quotient bit per cycle per axis).
// Reset: asynchronous, clears the sequencer and output valid; extrude_length = 100000.
module rect_shadow_silhouette_extruder #(
    parameter int FRAC_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rsse_pkg::LW-1:0]        cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [rsse_pkg::CW-1:0] light_x,
    input  logic signed [rsse_pkg::CW-1:0] light_y,
    input  logic signed [rsse_pkg::CW-1:0] rect_left,
    input  logic signed [rsse_pkg::CW-1:0] rect_top,
    input  logic signed [rsse_pkg::CW-1:0] rect_right,
    input  logic signed [rsse_pkg::CW-1:0] rect_bottom,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [rsse_pkg::VW-1:0] vertex_x,
    output logic signed [rsse_pkg::VW-1:0] vertex_y,
    output logic [1:0]                     outcome,
    output logic                           last_vertex
);
    import rsse_pkg::*;

    top_state_t           state_reg, state_next;
    logic [LW-1:0]        len_reg;
    logic signed [CW-1:0] lx_reg, ly_reg, le_reg, tp_reg, rt_reg, bt_reg;
    logic [1:0]           sel_reg [3];
    logic [1:0]           sel_next [3];
    logic                 n3_reg, n3_next;
    logic [1:0]           stat_reg, stat_next;
    logic [1:0]           idx_reg, idx_next;
    logic signed [VW-1:0] exx_reg, exy_reg;
    logic                 ov_reg, ov_next;
    logic signed [VW-1:0] vx_reg, vy_reg, vx_next, vy_next;
    logic [1:0]           oc_reg, oc_next;
    logic                 last_reg, last_next;
    logic                 load;

    logic                 in_rect, xbet, ybet, empty, n3c;
    logic [1:0]           c0, c1, c2;
    logic [1:0]           cur;
    logic signed [CW-1:0] cxv, cyv;
    logic                 out_free;
    ext_req_t             req;
    ext_rsp_t             rsp;

    // region classification on the input beat
    always_comb
    begin
        in_rect = (rect_left < light_x) && (rect_right > light_x) &&
                  (rect_top < light_y) && (rect_bottom > light_y);
        ybet   = (rect_top <= light_y) && (light_y <= rect_bottom);
        xbet   = (rect_left <= light_x) && (light_x <= rect_right);
        empty  = 1'b0;
        n3c    = 1'b0;
        c0     = CRN_LT;
        c1     = CRN_LB;
        c2     = CRN_LB;
        if (rect_left > light_x && ybet)
        begin
            c0 = CRN_LT; c1 = CRN_LB;
        end
        else if (rect_right <= light_x && ybet)
        begin
            c0 = CRN_RT; c1 = CRN_RB;
        end
        else if (rect_top > light_y && xbet)
        begin
            c0 = CRN_LT; c1 = CRN_RT;
        end
        else if (rect_bottom <= light_y && xbet)
        begin
            c0 = CRN_RB; c1 = CRN_LB;
        end
        else if (rect_left > light_x && rect_top > light_y)
        begin
            c0 = CRN_RT; c1 = CRN_LT; c2 = CRN_LB; n3c = 1'b1;
        end
        else if (rect_left > light_x && rect_bottom <= light_y)
        begin
            c0 = CRN_LT; c1 = CRN_LB; c2 = CRN_RB; n3c = 1'b1;
        end
        else if (rect_right <= light_x && rect_top > light_y)
        begin
            c0 = CRN_LT; c1 = CRN_RT; c2 = CRN_RB; n3c = 1'b1;
        end
        else if (rect_right <= light_x && rect_bottom <= light_y)
        begin
            c0 = CRN_RT; c1 = CRN_RB; c2 = CRN_LB; n3c = 1'b1;
        end
        else
            empty = 1'b1;
    end

    assign cur = sel_reg[idx_reg];

    always_comb
    begin
        case (cur)
            CRN_LT:
            begin
                cxv = le_reg; cyv = tp_reg;
            end
            CRN_RT:
            begin
                cxv = rt_reg; cyv = tp_reg;
            end
            CRN_RB:
            begin
                cxv = rt_reg; cyv = bt_reg;
            end
            default:
            begin
                cxv = le_reg; cyv = bt_reg;
            end
        endcase
    end

    assign out_free  = !ov_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        n3_next     = n3_reg;
        stat_next   = stat_reg;
        idx_next    = idx_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        oc_next     = oc_reg;
        last_next   = last_reg;
        ov_next     = ov_reg && !out_ready;
        load        = 1'b0;
        in_ready    = 1'b0;
        req.start   = 1'b0;
        req.cx      = cxv;
        req.cy      = cyv;
        case (state_reg)
            T_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    load        = 1'b1;
                    sel_next[0] = c0;
                    sel_next[1] = c1;
                    sel_next[2] = c2;
                    n3_next     = n3c;
                    idx_next    = 2'd0;
                    stat_next   = in_rect ? OC_INSIDE : OC_EMPTY;
                    state_next  = (in_rect || empty) ? T_STATUS : T_CORNER;
                end
            end
            T_STATUS:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    vx_next    = '0;
                    vy_next    = '0;
                    oc_next    = stat_reg;
                    last_next  = 1'b1;
                    state_next = T_IDLE;
                end
            end
            T_CORNER:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    vx_next   = VW'(cxv);
                    vy_next   = VW'(cyv);
                    oc_next   = OC_VERTEX;
                    last_next = 1'b0;
                    if (idx_reg == (n3_reg ? 2'd2 : 2'd1))
                        state_next = T_EXT;
                    else
                        idx_next = idx_reg + 2'd1;
                end
            end
            T_EXT:
            begin
                req.start  = 1'b1;
                state_next = T_WAIT;
            end
            T_WAIT:
            begin
                if (rsp.done)
                    state_next = T_PUT;
            end
            T_PUT:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    vx_next   = exx_reg;
                    vy_next   = exy_reg;
                    oc_next   = OC_VERTEX;
                    last_next = (idx_reg == 2'd0);
                    if (idx_reg == 2'd0)
                        state_next = T_IDLE;
                    else
                    begin
                        // middle corner of three is not pushed
                        idx_next   = (n3_reg && idx_reg == 2'd2) ? 2'd0 : idx_reg - 2'd1;
                        state_next = T_EXT;
                    end
                end
            end
            default:
                state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= T_IDLE;
            ov_reg    <= 1'b0;
            len_reg   <= LEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cfg_we)
                len_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lx_reg <= light_x;
            ly_reg <= light_y;
            le_reg <= rect_left;
            tp_reg <= rect_top;
            rt_reg <= rect_right;
            bt_reg <= rect_bottom;
        end
        if (rsp.done)
        begin
            exx_reg <= rsp.ex;
            exy_reg <= rsp.ey;
        end
        sel_reg  <= sel_next;
        n3_reg   <= n3_next;
        stat_reg <= stat_next;
        idx_reg  <= idx_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        oc_reg   <= oc_next;
        last_reg <= last_next;
    end

    rsse_extrude #(
        .FRAC_BITS(FRAC_BITS)
    ) u_extrude (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .lx   (lx_reg),
        .ly   (ly_reg),
        .len  (len_reg),
        .rsp  (rsp)
    );

    assign out_valid   = ov_reg;
    assign vertex_x    = vx_reg;
    assign vertex_y    = vy_reg;
    assign outcome     = oc_reg;
    assign last_vertex = last_reg;

`ifndef ASSERT_OFF
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");
    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> state_reg == T_WAIT)
        else $error("extrusion finished outside wait");
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome != OC_VERTEX) |->
            (vertex_x == '0 && vertex_y == '0 && last_vertex))
        else $error("malformed status beat");
`endif

endmodule
